// ----- rtl/core/cab_pkg.sv -----
// Shared types, constants and blend arithmetic for the clipped alpha blitter.
// Used by cab_front, cab_queue, cab_back and clipped_alpha_blit_top.
package cab_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int DIM_W     = 13;
    localparam int COORD_W   = 12;
    localparam int POS_W     = 14;
    localparam int CFG_IDX_W = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);

    // floor(t / 255) == (t * BLEND_RECIP) >> BLEND_SHIFT for t below 66052
    localparam int BLEND_RECIP = 32897;
    localparam int BLEND_SHIFT = 23;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_PIXEL = 1'b1
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BITMAP_W = 3'd0,
        CFG_BITMAP_H = 3'd1,
        CFG_FRAME_W  = 3'd2,
        CFG_FRAME_H  = 3'd3,
        CFG_PLACE_X  = 3'd4,
        CFG_PLACE_Y  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic               has_write;
        logic [COORD_W-1:0] write_x;
        logic [COORD_W-1:0] write_y;
        logic               fetch_valid;
        logic [COORD_W-1:0] fetch_src_col;
        logic [COORD_W-1:0] fetch_src_row;
        logic [COORD_W-1:0] fetch_dst_x;
        logic [COORD_W-1:0] fetch_dst_y;
        logic               done;
    } t_blit_meta;

    typedef struct packed {
        t_blit_meta  meta;
        logic [31:0] src;
        logic [23:0] dst;
    } t_blit_cmd;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
    endfunction

    // d*(255-a) + s*a + 127, at most 65152
    function automatic logic [15:0] blend_sum(input logic [7:0] s, input logic [7:0] d,
                                              input logic [7:0] a);
        logic [16:0] sum;
        sum = 17'(d) * 17'(8'd255 - a) + 17'(s) * 17'(a) + 17'd127;
        return sum[15:0];
    endfunction

    function automatic logic [7:0] blend_div(input logic [15:0] t);
        logic [31:0] p;
        p = 32'(t) * 32'(BLEND_RECIP);
        return p[BLEND_SHIFT +: 8];
    endfunction

endpackage

// ----- rtl/core/clipped_alpha_blit_top.sv -----
// Top level of the clipped alpha blitter: front end, command queue, back end.
// Depends on cab_pkg, cab_front, cab_queue, cab_back.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------------
//   input   | in        | i_in_valid / o_in_stall | i_req_type, i_src_pixel, i_dst_pixel
//   result  | out       | o_out_valid/i_out_stall | o_has_write .. o_done_res
//   config  | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while i_out_stall is low; a result passes through the queue entry,
// the blend sum stage and the reciprocal divide into the output register.
// The four-entry queue absorbs result stalls; input stalls only when it is full.
// Synchronous active-low reset clears control state; config resets to its defaults.
// Config writes are always taken (o_cfg_ready is tied high).
module clipped_alpha_blit_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cab_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cab_pkg::POS_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_req_type,
    input  logic [31:0]                   i_src_pixel,
    input  logic [31:0]                   i_dst_pixel,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_has_write,
    output logic [23:0]                   o_write_pixel,
    output logic [cab_pkg::COORD_W-1:0]   o_write_x,
    output logic [cab_pkg::COORD_W-1:0]   o_write_y,
    output logic                          o_fetch_valid,
    output logic [cab_pkg::COORD_W-1:0]   o_fetch_src_col,
    output logic [cab_pkg::COORD_W-1:0]   o_fetch_src_row,
    output logic [cab_pkg::COORD_W-1:0]   o_fetch_dst_x,
    output logic [cab_pkg::COORD_W-1:0]   o_fetch_dst_y,
    output logic                          o_done_res
);
    import cab_pkg::*;

    logic       push, pop, q_full, q_valid;
    t_blit_cmd  front_cmd, q_cmd;
    t_blit_meta out_meta;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;

    cab_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .i_src_pixel (i_src_pixel),
        .i_dst_pixel (i_dst_pixel),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    cab_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    cab_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_meta      (out_meta),
        .o_pixel     (o_write_pixel)
    );

    assign o_has_write     = out_meta.has_write;
    assign o_write_x       = out_meta.write_x;
    assign o_write_y       = out_meta.write_y;
    assign o_fetch_valid   = out_meta.fetch_valid;
    assign o_fetch_src_col = out_meta.fetch_src_col;
    assign o_fetch_src_row = out_meta.fetch_src_row;
    assign o_fetch_dst_x   = out_meta.fetch_dst_x;
    assign o_fetch_dst_y   = out_meta.fetch_dst_y;
    assign o_done_res      = out_meta.done;

endmodule

// ----- rtl/core/cab_front.sv -----
// Front end: configuration registers, request classification, clip window
// setup and the row-by-row coordinate walk. Depends on cab_pkg.
module cab_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [cab_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cab_pkg::POS_W-1:0]  i_cfg_data,
    input  logic                       i_in_valid,
    input  logic                       i_req_type,
    input  logic [31:0]                i_src_pixel,
    input  logic [31:0]                i_dst_pixel,
    input  logic                       i_q_full,
    output logic                       o_push,
    output cab_pkg::t_blit_cmd         o_cmd
);
    import cab_pkg::*;

    logic [DIM_W-1:0] r_bw, r_bh, r_fw, r_fh;
    logic [POS_W-1:0] r_px, r_py;

    logic [DIM_W-1:0] r_cur_x, r_cur_y, r_clip_min_x, r_clip_max_x, r_clip_max_y;
    logic [DIM_W-1:0] r_src_col_start, r_src_row;
    logic             r_active;

    logic [DIM_W-1:0] n_cur_x, n_cur_y, n_clip_min_x, n_clip_max_x, n_clip_max_y;
    logic [DIM_W-1:0] n_src_col_start, n_src_row;
    logic             n_active;

    logic             accept;
    logic             is_start;

    // start window
    logic signed [15:0] minx0, miny0, maxx0, maxy0, minx, miny, maxx, maxy;
    logic signed [15:0] offx, offy, fw16, fh16;
    logic               empty;
    logic [DIM_W-1:0]   start_row;

    // walk step
    logic [DIM_W-1:0]   step_x, nx, ny, nrow;
    logic               wrap, fin;

    assign accept   = i_in_valid && !i_q_full;
    assign is_start = (i_req_type == REQ_START);
    assign o_push   = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bw <= DIM_W'(1);
            r_bh <= DIM_W'(1);
            r_fw <= DIM_W'(1);
            r_fh <= DIM_W'(1);
            r_px <= '0;
            r_py <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BITMAP_W: r_bw <= i_cfg_data[DIM_W-1:0];
                CFG_BITMAP_H: r_bh <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_W:  r_fw <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_H:  r_fh <= i_cfg_data[DIM_W-1:0];
                CFG_PLACE_X:  r_px <= i_cfg_data;
                CFG_PLACE_Y:  r_py <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        minx0 = {{(16-POS_W){r_px[POS_W-1]}}, r_px};
        miny0 = {{(16-POS_W){r_py[POS_W-1]}}, r_py};
        maxx0 = minx0 + $signed({3'b000, sat_dim(r_bw)});
        maxy0 = miny0 + $signed({3'b000, sat_dim(r_bh)});
        fw16  = $signed({3'b000, sat_dim(r_fw)});
        fh16  = $signed({3'b000, sat_dim(r_fh)});
        offx  = (minx0 < 0) ? -minx0 : 16'sd0;
        offy  = (miny0 < 0) ? -miny0 : 16'sd0;
        minx  = (minx0 < 0) ? 16'sd0 : minx0;
        miny  = (miny0 < 0) ? 16'sd0 : miny0;
        maxx  = (maxx0 > fw16) ? fw16 : maxx0;
        maxy  = (maxy0 > fh16) ? fh16 : maxy0;
        empty = (minx >= maxx) || (miny >= maxy);
        // stored row of the first frame row: rows are kept bottom-up
        start_row = sat_dim(r_bh) - DIM_W'(1) - offy[DIM_W-1:0];
    end

    always_comb begin
        step_x = r_cur_x + DIM_W'(1);
        wrap   = (step_x >= r_clip_max_x);
        nx     = wrap ? r_clip_min_x : step_x;
        ny     = wrap ? r_cur_y + DIM_W'(1) : r_cur_y;
        nrow   = wrap ? r_src_row - DIM_W'(1) : r_src_row;
        fin    = (ny >= r_clip_max_y);
    end

    always_comb begin
        n_cur_x         = r_cur_x;
        n_cur_y         = r_cur_y;
        n_clip_min_x    = r_clip_min_x;
        n_clip_max_x    = r_clip_max_x;
        n_clip_max_y    = r_clip_max_y;
        n_src_col_start = r_src_col_start;
        n_src_row       = r_src_row;
        n_active        = r_active;
        o_cmd           = '0;

        if (is_start) begin
            if (empty) begin
                n_active       = 1'b0;
                o_cmd.meta.done = 1'b1;
            end else begin
                n_cur_x         = minx[DIM_W-1:0];
                n_cur_y         = miny[DIM_W-1:0];
                n_clip_min_x    = minx[DIM_W-1:0];
                n_clip_max_x    = maxx[DIM_W-1:0];
                n_clip_max_y    = maxy[DIM_W-1:0];
                n_src_col_start = offx[DIM_W-1:0];
                n_src_row       = start_row;
                n_active        = 1'b1;
                o_cmd.meta.fetch_valid   = 1'b1;
                o_cmd.meta.fetch_src_col = offx[COORD_W-1:0];
                o_cmd.meta.fetch_src_row = start_row[COORD_W-1:0];
                o_cmd.meta.fetch_dst_x   = minx[COORD_W-1:0];
                o_cmd.meta.fetch_dst_y   = miny[COORD_W-1:0];
            end
        end else if (!r_active) begin
            o_cmd.meta.done = 1'b1;
        end else begin
            o_cmd.meta.has_write = 1'b1;
            o_cmd.meta.write_x   = r_cur_x[COORD_W-1:0];
            o_cmd.meta.write_y   = r_cur_y[COORD_W-1:0];
            o_cmd.src            = i_src_pixel;
            o_cmd.dst            = i_dst_pixel[23:0];
            n_cur_x   = nx;
            n_cur_y   = ny;
            n_src_row = nrow;
            if (fin) begin
                n_active        = 1'b0;
                o_cmd.meta.done = 1'b1;
            end else begin
                o_cmd.meta.fetch_valid   = 1'b1;
                o_cmd.meta.fetch_src_col =
                    COORD_W'(r_src_col_start + nx - r_clip_min_x);
                o_cmd.meta.fetch_src_row = nrow[COORD_W-1:0];
                o_cmd.meta.fetch_dst_x   = nx[COORD_W-1:0];
                o_cmd.meta.fetch_dst_y   = ny[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x         <= '0;
            r_cur_y         <= '0;
            r_clip_min_x    <= '0;
            r_clip_max_x    <= '0;
            r_clip_max_y    <= '0;
            r_src_col_start <= '0;
            r_src_row       <= '0;
            r_active        <= 1'b0;
        end else if (accept) begin
            r_cur_x         <= n_cur_x;
            r_cur_y         <= n_cur_y;
            r_clip_min_x    <= n_clip_min_x;
            r_clip_max_x    <= n_clip_max_x;
            r_clip_max_y    <= n_clip_max_y;
            r_src_col_start <= n_src_col_start;
            r_src_row       <= n_src_row;
            r_active        <= n_active;
        end
    end

`ifndef SYNTH
    a_walk_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_cur_x < r_clip_max_x) && (r_cur_y < r_clip_max_y)
                     && (r_cur_x >= r_clip_min_x))
        else $error("coordinate walk left the clip window");
`endif

endmodule

// ----- rtl/core/cab_queue.sv -----
// Short command queue between front and back ends.
// Depends on cab_pkg for the command type and depth.
module cab_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cab_pkg::t_blit_cmd i_cmd,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output cab_pkg::t_blit_cmd o_cmd
);
    import cab_pkg::*;

    t_blit_cmd         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(do_pop);
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into a full queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count above depth");
`endif

endmodule

// ----- rtl/core/cab_back.sv -----
// Back end: two-stage blend pipeline (weighted sum register, then divide by 255 via
// reciprocal multiply into the output register). Depends on cab_pkg.
module cab_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  cab_pkg::t_blit_cmd          i_cmd,
    output logic                        o_pop,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output cab_pkg::t_blit_meta         o_meta,
    output logic [23:0]                 o_pixel
);
    import cab_pkg::*;

    logic        r_s1_valid;
    t_blit_meta  r_s1_meta;
    logic [15:0] r_s1_sum_r, r_s1_sum_g, r_s1_sum_b;

    logic        r_out_valid;
    t_blit_meta  r_out_meta;
    logic [23:0] r_out_pixel;

    logic        out_adv, s1_adv;
    logic [7:0]  alpha;

    assign alpha   = i_cmd.src[31:24];
    assign out_adv = !r_out_valid || !i_out_stall;
    assign s1_adv  = !r_s1_valid || out_adv;
    assign o_pop   = s1_adv;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1_meta  <= i_cmd.meta;
            r_s1_sum_r <= blend_sum(i_cmd.src[23:16], i_cmd.dst[23:16], alpha);
            r_s1_sum_g <= blend_sum(i_cmd.src[15:8], i_cmd.dst[15:8], alpha);
            r_s1_sum_b <= blend_sum(i_cmd.src[7:0], i_cmd.dst[7:0], alpha);
        end
        if (out_adv) begin
            r_out_meta <= r_s1_meta;
            // zero the pixel when nothing is written
            r_out_pixel <= r_s1_meta.has_write
                ? {blend_div(r_s1_sum_r), blend_div(r_s1_sum_g), blend_div(r_s1_sum_b)}
                : 24'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= i_q_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_meta      = r_out_meta;
    assign o_pixel     = r_out_pixel;

`ifndef SYNTH
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> r_s1_valid && $stable(r_s1_meta)
                                    && $stable(r_s1_sum_r))
        else $error("blend stage lost data while stalled");
`endif

endmodule
